// File: sv/kfe_pkg.sv
// Shared constants and types for the KISS frame encoder.
package kfe_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 13;
  localparam int MAX_CANDS = 5;
  localparam int CNT_W     = 3;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [BYTE_W-1:0] FEND  = 8'hC0;
  localparam logic [BYTE_W-1:0] FESC  = 8'hDB;
  localparam logic [BYTE_W-1:0] TFEND = 8'hDC;
  localparam logic [BYTE_W-1:0] TFESC = 8'hDD;
  localparam logic [BYTE_W-1:0] CMD   = 8'h00;

  localparam logic [LEN_W-1:0] DEFAULT_MAX_LEN = 13'd1024;

  // Register index, taken from paddr[2].
  localparam logic REG_MAX_LEN = 1'b0;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_in_frame;
    logic              no_data;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              frame_done;
    logic              too_long;
    logic [LEN_W-1:0]  frame_length;
    logic              last_of_run;
  } result_t;

  // One classified item: the bytes to send, whether an error result follows,
  // and whether the final byte closes the frame.
  typedef struct packed {
    logic [MAX_CANDS-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]                 sent;
    logic                             ovf;
    logic                             close;
    logic [LEN_W-1:0]                 length;
  } job_t;

endpackage

// File: sv/kfe_front.sv
// Front end: framing state, escape classification and capacity check per item.
module kfe_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  kfe_pkg::item_t               item,
  input  logic [kfe_pkg::LEN_W-1:0]    max_len,
  output logic                         job_push,
  output kfe_pkg::job_t                job
);

  logic                        in_frame;
  logic                        dropping;
  logic [kfe_pkg::LEN_W-1:0]   out_count;

  logic [kfe_pkg::MAX_CANDS-1:0][kfe_pkg::BYTE_W-1:0] bytes;
  logic [kfe_pkg::CNT_W-1:0]   ncand;
  logic [kfe_pkg::LEN_W-1:0]   room;
  logic                        ovf;
  logic [kfe_pkg::CNT_W-1:0]   sent;
  logic [kfe_pkg::LEN_W-1:0]   length;
  logic                        is_special;

  always_comb begin
    bytes = '0;
    ncand = '0;
    is_special = (item.data_byte == kfe_pkg::FEND) || (item.data_byte == kfe_pkg::FESC);
    if (!in_frame) begin
      bytes[0] = kfe_pkg::FEND;
      bytes[1] = kfe_pkg::CMD;
      ncand = 3'd2;
    end
    if (!item.no_data) begin
      if (is_special) begin
        bytes[ncand] = kfe_pkg::FESC;
        bytes[3'(ncand + 3'd1)] = (item.data_byte == kfe_pkg::FEND) ?
                                  kfe_pkg::TFEND : kfe_pkg::TFESC;
        ncand = 3'(ncand + 3'd2);
      end else begin
        bytes[ncand] = item.data_byte;
        ncand = 3'(ncand + 3'd1);
      end
    end
    if (item.last_in_frame) begin
      bytes[ncand] = kfe_pkg::FEND;
      ncand = 3'(ncand + 3'd1);
    end
    room   = (out_count < max_len) ? (max_len - out_count) : '0;
    ovf    = {{(kfe_pkg::LEN_W-kfe_pkg::CNT_W){1'b0}}, ncand} > room;
    sent   = ovf ? room[kfe_pkg::CNT_W-1:0] : ncand;
    length = out_count + {{(kfe_pkg::LEN_W-kfe_pkg::CNT_W){1'b0}}, ncand};
  end

  assign job.bytes  = bytes;
  assign job.sent   = sent;
  assign job.ovf    = ovf;
  assign job.close  = item.last_in_frame && !ovf;
  assign job.length = length;

  // Items that are being dropped, and open-frame items with nothing to send,
  // leave no entry behind.
  assign job_push = accept && !dropping && ((sent != '0) || ovf);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      dropping  <= 1'b0;
      out_count <= '0;
    end else if (accept) begin
      if (dropping) begin
        if (item.last_in_frame) begin
          dropping  <= 1'b0;
          in_frame  <= 1'b0;
          out_count <= '0;
        end
      end else if (ovf) begin
        out_count <= '0;
        if (item.last_in_frame) begin
          in_frame <= 1'b0;
        end else begin
          in_frame <= 1'b1;
          dropping <= 1'b1;
        end
      end else if (item.last_in_frame) begin
        in_frame  <= 1'b0;
        out_count <= '0;
      end else begin
        in_frame  <= 1'b1;
        out_count <= length;
      end
    end
  end

endmodule

// File: sv/kfe_queue.sv
// Short queue of classified items between the front and back ends.
module kfe_queue #(
  parameter int DEPTH = kfe_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  kfe_pkg::job_t wdata,
  output logic          full,
  input  logic          rd,
  output kfe_pkg::job_t rdata,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kfe_pkg::job_t     slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (wr && !rd) begin
        count <= CNT_W'(count + 1'b1);
      end else if (rd && !wr) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

// File: sv/kfe_back.sv
// Back end: walks each queued item into the output register, one result per cycle while not stalled.
module kfe_back (
  input  logic              clk,
  input  logic              rst,
  input  kfe_pkg::job_t     job,
  input  logic              job_empty,
  output logic              job_pop,
  output kfe_pkg::result_t  result,
  output logic              empty,
  input  logic              pop
);

  logic [kfe_pkg::CNT_W-1:0] idx;
  logic                      out_valid;
  kfe_pkg::result_t          res;
  logic [kfe_pkg::CNT_W-1:0] total;
  logic                      advance;
  logic                      is_byte;

  always_comb begin
    total   = 3'(job.sent + {2'b00, job.ovf});
    is_byte = idx < job.sent;
    res = '0;
    if (is_byte) begin
      res.out_byte   = job.bytes[idx];
      res.frame_done = job.close && (idx == 3'(job.sent - 3'd1));
      res.frame_length = res.frame_done ? job.length : '0;
    end else begin
      res.too_long = 1'b1;
    end
    res.last_of_run = (idx == 3'(total - 3'd1));
  end

  assign advance = !job_empty && (!out_valid || pop);
  assign job_pop = advance && res.last_of_run;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
      idx       <= res.last_of_run ? '0 : 3'(idx + 3'd1);
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  a_error_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.too_long |-> result.last_of_run && result.out_byte == '0)
    else $error("error result is not the last of its run or carries a byte");

  a_done_is_fend: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.frame_done |->
      result.out_byte == kfe_pkg::FEND && result.last_of_run && !result.too_long)
    else $error("frame close is not a final FEND");

  a_len_only_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.frame_done |-> result.frame_length == '0)
    else $error("frame length reported outside frame close");

  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    !job_empty |-> idx < total)
    else $error("result index runs past the queued item");

endmodule

// File: sv/kiss_frame_encoder.sv
// Top level of the KISS frame encoder: register port and wiring of front, queue and back.
//
// Frame bytes go in through a queue-style port: an item is taken on a clock edge
// with push high and full low. Each item carries a byte, a last-of-frame mark and
// a no-data flag for empty frames. Encoded bytes come out through a queue-style
// port: while empty is low the oldest result is on result, and pop takes it.
// The first item of a frame is preceded by FEND and the command byte, 0xC0 and
// 0xDB are escaped, and the last item closes the frame with FEND and its length.
// If a byte would exceed max_output_len, one too_long result ends the item and
// the rest of the frame is discarded.
// Items are classified on acceptance and one new item can be taken every cycle
// while the internal queue has room. The back end sends one result per cycle
// while the receiver keeps up, and an item causes up to five results. The first
// result of an item passes through the queue and then the output register.
// When the receiver stalls, results wait in the output register and queue, and
// full rises once the queue is full. Reset closes any frame, empties the queue
// and sets max_output_len to 1024. Write the register only while idle.
module kiss_frame_encoder #(
  parameter int QUEUE_DEPTH = kfe_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  kfe_pkg::item_t                item,
  output logic                          empty,
  input  logic                          pop,
  output kfe_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kfe_pkg::PADDR_W-1:0]   paddr,
  input  logic [kfe_pkg::PDATA_W-1:0]   pwdata,
  output logic [kfe_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [kfe_pkg::LEN_W-1:0] max_output_len;
  logic                      accept;
  logic                      job_push;
  logic                      job_pop;
  logic                      job_empty;
  logic                      q_full;
  kfe_pkg::job_t             job_in;
  kfe_pkg::job_t             job_out;

  assign pready = 1'b1;
  assign full   = q_full;
  assign accept = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_len <= kfe_pkg::DEFAULT_MAX_LEN;
    end else if (psel && penable && pwrite && (paddr[2] == kfe_pkg::REG_MAX_LEN)) begin
      max_output_len <= pwdata[kfe_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == kfe_pkg::REG_MAX_LEN) begin
      prdata = {{(kfe_pkg::PDATA_W-kfe_pkg::LEN_W){1'b0}}, max_output_len};
    end
  end

  kfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .max_len  (max_output_len),
    .job_push (job_push),
    .job      (job_in)
  );

  kfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (job_push),
    .wdata (job_in),
    .full  (q_full),
    .rd    (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  kfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
